FILE: sv/hrp_pkg.sv
// shared types, constants and helpers for the http request header parser
`timescale 1ns / 1ps
package hrp_pkg;

  localparam int LEN_BITS    = 12;
  localparam int POS_BITS    = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int GET_LEN     = 4;
  localparam int POST_LEN    = 5;
  localparam int VER_LEN     = 10;

  localparam logic [0:GET_LEN-1][7:0]  GET_TEXT     = "GET ";
  localparam logic [0:POST_LEN-1][7:0] POST_TEXT    = "POST ";
  localparam logic [0:VER_LEN-1][7:0]  VERSION_TEXT = {"HTTP/1.1", 8'h0D, 8'h0A};

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [LEN_BITS-1:0] MAX_URI_RESET   = LEN_BITS'(256);
  localparam logic [LEN_BITS-1:0] MAX_KEY_RESET   = LEN_BITS'(64);
  localparam logic [LEN_BITS-1:0] MAX_VALUE_RESET = LEN_BITS'(1024);

  typedef enum logic [1:0] {
    REG_MAX_URI   = 2'd0,
    REG_MAX_KEY   = 2'd1,
    REG_MAX_VALUE = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ROLE_DELIM   = 3'd0,
    ROLE_METHOD  = 3'd1,
    ROLE_URI     = 3'd2,
    ROLE_VERSION = 3'd3,
    ROLE_KEY     = 3'd4,
    ROLE_VALUE   = 3'd5,
    ROLE_IGNORED = 3'd6
  } role_t;

  typedef enum logic [1:0] {
    METHOD_NONE = 2'd0,
    METHOD_GET  = 2'd1,
    METHOD_POST = 2'd2
  } method_t;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_BAD_METHOD  = 3'd1,
    ERR_URI_LONG    = 3'd2,
    ERR_BAD_VERSION = 3'd3,
    ERR_KEY_LONG    = 3'd4,
    ERR_VALUE_LONG  = 3'd5
  } err_t;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_URI,
    PH_VERSION,
    PH_KEY,
    PH_VALUE,
    PH_DONE,
    PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_request;
  } hrp_in_t;

  typedef struct packed {
    logic [2:0] byte_role;
    logic [7:0] echo_byte;
    logic [1:0] method_seen;
    logic       field_end;
    logic       request_done;
    logic [2:0] error_code;
  } hrp_out_t;

  // byte plus its precomputed character matches
  typedef struct packed {
    logic [7:0]         data_byte;
    logic               start_request;
    logic               is_cr;
    logic               is_lf;
    logic               is_space;
    logic               is_colon;
    logic [GET_LEN-1:0]  get_hit;
    logic [POST_LEN-1:0] post_hit;
    logic [VER_LEN-1:0]  ver_hit;
  } hrp_class_t;

  function automatic logic [LEN_BITS-1:0] inc_sat(input logic [LEN_BITS-1:0] v);
    inc_sat = (&v) ? v : LEN_BITS'(v + 1'b1);
  endfunction

endpackage

FILE: sv/hrp_front.sv
// front end: takes bytes and tags them with their character matches
`timescale 1ns / 1ps
module hrp_front import hrp_pkg::*; (
  input  logic       byte_valid,
  input  hrp_in_t    byte_item,
  input  logic       queue_full,
  output logic       push,
  output hrp_class_t push_item
);

  assign push = byte_valid & ~queue_full;

  always_comb begin
    push_item.data_byte     = byte_item.data_byte;
    push_item.start_request = byte_item.start_request;
    push_item.is_cr         = (byte_item.data_byte == CHAR_CR);
    push_item.is_lf         = (byte_item.data_byte == CHAR_LF);
    push_item.is_space      = (byte_item.data_byte == CHAR_SPACE);
    push_item.is_colon      = (byte_item.data_byte == CHAR_COLON);
    for (int i = 0; i < GET_LEN; i++) begin
      push_item.get_hit[i] = (byte_item.data_byte == GET_TEXT[i]);
    end
    for (int i = 0; i < POST_LEN; i++) begin
      push_item.post_hit[i] = (byte_item.data_byte == POST_TEXT[i]);
    end
    for (int i = 0; i < VER_LEN; i++) begin
      push_item.ver_hit[i] = (byte_item.data_byte == VERSION_TEXT[i]);
    end
  end

endmodule

FILE: sv/hrp_queue.sv
// small fifo between the classifier and the parser
`timescale 1ns / 1ps
module hrp_queue import hrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  hrp_class_t push_item,
  input  logic       pop,
  output logic       full,
  output logic       not_empty,
  output hrp_class_t head_item
);

  hrp_class_t mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= QPTR_BITS'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= QPTR_BITS'(rd_ptr + 1'b1);
      end
      case ({push, pop})
        2'b10:   count <= QCNT_BITS'(count + 1'b1);
        2'b01:   count <= QCNT_BITS'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/hrp_back.sv
// back end: parse state machine, limit registers and result register
`timescale 1ns / 1ps
module hrp_back import hrp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [LEN_BITS-1:0] cfg_data,
  input  logic                not_empty,
  input  hrp_class_t          head_item,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output hrp_out_t            result_item
);

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_METHOD_STEP,
    ACT_METHOD_END,
    ACT_URI_BYTE,
    ACT_URI_END,
    ACT_VER_BYTE,
    ACT_VER_DELIM,
    ACT_VER_END,
    ACT_KEY_BYTE,
    ACT_KEY_CR,
    ACT_KEY_END,
    ACT_BLANK_LINE,
    ACT_VALUE_BYTE,
    ACT_VALUE_CR,
    ACT_VALUE_END
  } act_t;

  logic [LEN_BITS-1:0] max_uri_len;
  logic [LEN_BITS-1:0] max_key_len;
  logic [LEN_BITS-1:0] max_value_len;

  phase_t              phase;
  logic [POS_BITS-1:0] match_pos;
  logic [LEN_BITS-1:0] field_len;
  logic [1:0]          cand;
  logic [1:0]          found;
  logic                pending_cr;
  logic [2:0]          err;

  phase_t              phase_cur, phase_next;
  logic [POS_BITS-1:0] pos_cur, pos_next;
  logic [LEN_BITS-1:0] len_cur, len_next;
  logic [1:0]          cand_cur, cand_next;
  logic [1:0]          found_cur, found_next;
  logic                pend_cur, pend_next;
  logic [2:0]          err_cur, err_next;

  act_t                act;
  logic [2:0]          fail_code;
  logic [1:0]          cand_m;
  logic [1:0]          found_code;
  logic [LEN_BITS-1:0] len1;
  logic [LEN_BITS-1:0] len2;
  logic [LEN_BITS-1:0] len_new;
  logic                get_ok;
  logic                post_ok;
  logic                ver_ok;
  hrp_out_t            res;

  assign pop = not_empty & (~result_valid | ~result_stall);

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_uri_len   <= MAX_URI_RESET;
      max_key_len   <= MAX_KEY_RESET;
      max_value_len <= MAX_VALUE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_URI:   max_uri_len   <= cfg_data;
        REG_MAX_KEY:   max_key_len   <= cfg_data;
        REG_MAX_VALUE: max_value_len <= cfg_data;
        default:       max_uri_len   <= max_uri_len;
      endcase
    end
  end

  // decode: state seen by this byte and the action it takes
  always_comb begin
    if (head_item.start_request) begin
      phase_cur = PH_METHOD;
      pos_cur   = '0;
      len_cur   = '0;
      cand_cur  = 2'b11;
      found_cur = METHOD_NONE;
      pend_cur  = 1'b0;
      err_cur   = ERR_NONE;
    end else begin
      phase_cur = phase;
      pos_cur   = match_pos;
      len_cur   = field_len;
      cand_cur  = cand;
      found_cur = found;
      pend_cur  = pending_cr;
      err_cur   = err;
    end

    get_ok  = (pos_cur < POS_BITS'(GET_LEN)) ?
              head_item.get_hit[pos_cur[$clog2(GET_LEN)-1:0]] : 1'b0;
    post_ok = (pos_cur < POS_BITS'(POST_LEN)) ?
              head_item.post_hit[pos_cur[$clog2(POST_LEN)-1:0]] : 1'b0;
    ver_ok  = (pos_cur < POS_BITS'(VER_LEN)) ? head_item.ver_hit[pos_cur] : 1'b0;
    cand_m  = cand_cur & {post_ok, get_ok};

    len1       = pend_cur ? inc_sat(len_cur) : len_cur;
    len2       = inc_sat(len1);
    len_new    = len_cur;
    act        = ACT_NONE;
    fail_code  = ERR_NONE;
    found_code = found_cur;

    case (phase_cur)
      PH_METHOD: begin
        if (cand_m == 2'b00) begin
          act       = ACT_FAIL;
          fail_code = ERR_BAD_METHOD;
        end else if (cand_m[0] && pos_cur == POS_BITS'(GET_LEN - 1)) begin
          act        = ACT_METHOD_END;
          found_code = METHOD_GET;
        end else if (cand_m[1] && pos_cur == POS_BITS'(POST_LEN - 1)) begin
          act        = ACT_METHOD_END;
          found_code = METHOD_POST;
        end else begin
          act = ACT_METHOD_STEP;
        end
      end
      PH_URI: begin
        if (head_item.is_space) begin
          if (len_cur >= max_uri_len) begin
            act       = ACT_FAIL;
            fail_code = ERR_URI_LONG;
          end else begin
            act = ACT_URI_END;
          end
        end else begin
          len_new = inc_sat(len_cur);
          if (len_new >= max_uri_len) begin
            act       = ACT_FAIL;
            fail_code = ERR_URI_LONG;
          end else begin
            act = ACT_URI_BYTE;
          end
        end
      end
      PH_VERSION: begin
        if (!ver_ok) begin
          act       = ACT_FAIL;
          fail_code = ERR_BAD_VERSION;
        end else if (pos_cur == POS_BITS'(VER_LEN - 1)) begin
          act = ACT_VER_END;
        end else if (pos_cur < POS_BITS'(VER_LEN - 2)) begin
          act = ACT_VER_BYTE;
        end else begin
          act = ACT_VER_DELIM;
        end
      end
      PH_KEY: begin
        if (pend_cur && head_item.is_lf) begin
          act = ACT_BLANK_LINE;
        end else if (len1 == '0 && head_item.is_cr) begin
          act     = ACT_KEY_CR;
          len_new = len1;
        end else if (head_item.is_colon) begin
          if (len1 >= max_key_len) begin
            act       = ACT_FAIL;
            fail_code = ERR_KEY_LONG;
          end else begin
            act = ACT_KEY_END;
          end
        end else begin
          len_new = len2;
          if (len2 >= max_key_len) begin
            act       = ACT_FAIL;
            fail_code = ERR_KEY_LONG;
          end else begin
            act = ACT_KEY_BYTE;
          end
        end
      end
      PH_VALUE: begin
        if (pend_cur && head_item.is_lf) begin
          act = ACT_VALUE_END;
        end else if (pend_cur && len1 > max_value_len) begin
          act       = ACT_FAIL;
          fail_code = ERR_VALUE_LONG;
        end else if (head_item.is_cr) begin
          act     = ACT_VALUE_CR;
          len_new = len1;
        end else begin
          len_new = len2;
          if (len2 > max_value_len) begin
            act       = ACT_FAIL;
            fail_code = ERR_VALUE_LONG;
          end else begin
            act = ACT_VALUE_BYTE;
          end
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  // next state
  always_comb begin
    phase_next = phase_cur;
    pos_next   = pos_cur;
    len_next   = len_cur;
    cand_next  = cand_cur;
    found_next = found_cur;
    pend_next  = pend_cur;
    err_next   = err_cur;
    case (act)
      ACT_FAIL: begin
        err_next   = fail_code;
        phase_next = PH_ERROR;
        pend_next  = 1'b0;
      end
      ACT_METHOD_STEP: begin
        cand_next = cand_m;
        pos_next  = POS_BITS'(pos_cur + 1'b1);
      end
      ACT_METHOD_END: begin
        found_next = found_code;
        phase_next = PH_URI;
        pos_next   = '0;
        len_next   = '0;
      end
      ACT_URI_BYTE: len_next = len_new;
      ACT_URI_END: begin
        phase_next = PH_VERSION;
        pos_next   = '0;
        len_next   = '0;
      end
      ACT_VER_BYTE, ACT_VER_DELIM: pos_next = POS_BITS'(pos_cur + 1'b1);
      ACT_VER_END: begin
        phase_next = PH_KEY;
        pos_next   = '0;
        len_next   = '0;
        pend_next  = 1'b0;
      end
      ACT_KEY_CR, ACT_VALUE_CR: begin
        pend_next = 1'b1;
        len_next  = len_new;
      end
      ACT_KEY_BYTE, ACT_VALUE_BYTE: begin
        pend_next = 1'b0;
        len_next  = len_new;
      end
      ACT_KEY_END: begin
        phase_next = PH_VALUE;
        len_next   = '0;
        pend_next  = 1'b0;
      end
      ACT_VALUE_END: begin
        phase_next = PH_KEY;
        len_next   = '0;
        pend_next  = 1'b0;
      end
      ACT_BLANK_LINE: begin
        phase_next = PH_DONE;
        pend_next  = 1'b0;
      end
      default: phase_next = phase_cur;
    endcase
  end

  // result for this byte
  always_comb begin
    res.echo_byte    = head_item.data_byte;
    res.method_seen  = found_next;
    res.error_code   = err_next;
    res.field_end    = 1'b0;
    res.request_done = 1'b0;
    case (act)
      ACT_FAIL: begin
        case (phase_cur)
          PH_METHOD:  res.byte_role = ROLE_METHOD;
          PH_URI:     res.byte_role = ROLE_URI;
          PH_VERSION: res.byte_role = ROLE_VERSION;
          PH_KEY:     res.byte_role = ROLE_KEY;
          PH_VALUE:   res.byte_role = ROLE_VALUE;
          default:    res.byte_role = ROLE_IGNORED;
        endcase
      end
      ACT_METHOD_STEP: res.byte_role = ROLE_METHOD;
      ACT_URI_BYTE:    res.byte_role = ROLE_URI;
      ACT_VER_BYTE:    res.byte_role = ROLE_VERSION;
      ACT_KEY_BYTE:    res.byte_role = ROLE_KEY;
      ACT_VALUE_BYTE:  res.byte_role = ROLE_VALUE;
      ACT_VER_DELIM, ACT_KEY_CR, ACT_VALUE_CR: res.byte_role = ROLE_DELIM;
      ACT_METHOD_END, ACT_URI_END, ACT_VER_END, ACT_KEY_END, ACT_VALUE_END: begin
        res.byte_role = ROLE_DELIM;
        res.field_end = 1'b1;
      end
      ACT_BLANK_LINE: begin
        res.byte_role    = ROLE_DELIM;
        res.request_done = 1'b1;
      end
      default: res.byte_role = ROLE_IGNORED;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_METHOD;
      match_pos  <= '0;
      field_len  <= '0;
      cand       <= 2'b11;
      found      <= METHOD_NONE;
      pending_cr <= 1'b0;
      err        <= ERR_NONE;
    end else if (pop) begin
      phase      <= phase_next;
      match_pos  <= pos_next;
      field_len  <= len_next;
      cand       <= cand_next;
      found      <= found_next;
      pending_cr <= pend_next;
      err        <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_item <= res;
    end
  end

endmodule

FILE: sv/http_request_header_parser_top.sv
// top level of the http request header parser
`timescale 1ns / 1ps
//
//  channel   direction  handshake                   payload
//  byte      in         byte_valid / byte_stall     byte_item   (hrp_in_t)
//  result    out        result_valid / result_stall result_item (hrp_out_t)
//  cfg       in         cfg_we (no handshake back)  cfg_index, cfg_data
//
//  one byte per cycle sustained while result_stall stays low; a taken byte goes
//  into the fifo, and the parser pops the fifo head and registers its result
//  reset clears the fifo, the parse state and restores limits 256 / 64 / 1024
//  a stalled result holds in the output register while the 4-entry fifo keeps
//  taking bytes; byte_stall rises only when the fifo is full
//
module http_request_header_parser_top import hrp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // byte input channel
  input  logic                byte_valid,
  output logic                byte_stall,
  input  hrp_in_t             byte_item,
  // result output channel
  output logic                result_valid,
  input  logic                result_stall,
  output hrp_out_t            result_item,
  // limit register writes
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [LEN_BITS-1:0] cfg_data
);

  logic       push;
  logic       pop;
  logic       queue_full;
  logic       not_empty;
  hrp_class_t push_item;
  hrp_class_t head_item;

  // stall only from the registered fill count, never from byte_valid
  assign byte_stall = queue_full;

  // classify each byte as it is taken
  hrp_front u_front (
    .byte_valid (byte_valid),
    .byte_item  (byte_item),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // decouples the input side from output back pressure
  hrp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (not_empty),
    .head_item (head_item)
  );

  // parse state machine and the result register
  hrp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .not_empty    (not_empty),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

FILE: sv/hrp_checker.sv
// port level checks for the http request header parser
`timescale 1ns / 1ps
module hrp_checker import hrp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                result_valid,
  input logic                result_stall,
  input hrp_out_t            result_item
);

  // a stalled transaction stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_item))
    else $error("result transaction changed while stalled");

  // the parser cannot produce a result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // every field end and the end of the headers land on a delimiter
  a_end_is_delim: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_item.field_end || result_item.request_done) |->
      result_item.byte_role == ROLE_DELIM)
    else $error("field end on a non-delimiter byte");

  // the end of the headers is the lf of the blank line
  a_done_on_lf: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.request_done |->
      result_item.echo_byte == CHAR_LF && result_item.error_code == ERR_NONE)
    else $error("request done on a wrong byte");

  // a latched error suppresses all end flags
  a_err_no_flags: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.error_code != ERR_NONE |->
      !result_item.field_end && !result_item.request_done)
    else $error("end flag raised while in error");

endmodule

bind http_request_header_parser_top hrp_checker u_hrp_checker (.*);

FILE: bench/http_request_header_parser_top_tb.sv
// self-checking bench for the http request header parser: directed bytes, then random requests
`timescale 1ns / 1ps
module http_request_header_parser_top_tb;
  import hrp_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int BACKLOG     = 64;   // bytes kept queued ahead of the sender

  // our own copies of the fixed texts the parser matches against
  localparam logic [0:3][7:0] GET_STR  = "GET ";
  localparam logic [0:4][7:0] POST_STR = "POST ";
  localparam logic [0:9][7:0] VER_STR  = {"HTTP/1.1", 8'h0D, 8'h0A};
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // one queued input transaction; typed rows carry a hand-written expectation
  typedef struct packed {
    hrp_in_t  item;
    logic     typed;
    hrp_out_t want;
  } byte_txn_t;

  // directed row: byte, start flag, and the result where it is obvious
  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    role_t      role;
    method_t    method;
    logic       fend;
    logic       done;
    err_t       err;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // junk first byte: bad method, role stays method
    '{8'hFF, 1'b1, 1'b1, ROLE_METHOD,  METHOD_NONE, 1'b0, 1'b0, ERR_BAD_METHOD},
    // fault latched, byte ignored
    '{8'h00, 1'b0, 1'b1, ROLE_IGNORED, METHOD_NONE, 1'b0, 1'b0, ERR_BAD_METHOD},
    // start clears the fault
    '{"G",   1'b1, 1'b1, ROLE_METHOD,  METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"E",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"T",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{" ",   1'b0, 1'b1, ROLE_DELIM,   METHOD_GET,  1'b1, 1'b0, ERR_NONE},
    '{"/",   1'b0, 1'b1, ROLE_URI,     METHOD_GET,  1'b0, 1'b0, ERR_NONE},
    '{" ",   1'b0, 1'b1, ROLE_DELIM,   METHOD_GET,  1'b1, 1'b0, ERR_NONE},
    '{"H",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"T",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"T",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"P",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"/",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"1",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{".",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"1",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{8'h0D, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{8'h0A, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    // cr at key start, then a byte that is not lf: cr becomes a key byte
    '{8'h0D, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{"k",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{":",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    // value keeps its leading space
    '{" ",   1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{8'h0D, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{8'h0A, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    // blank line closes the header block
    '{8'h0D, 1'b0, 1'b0, ROLE_DELIM,   METHOD_NONE, 1'b0, 1'b0, ERR_NONE},
    '{8'h0A, 1'b0, 1'b1, ROLE_DELIM,   METHOD_GET,  1'b0, 1'b1, ERR_NONE},
    // body byte is ignored
    '{8'hFF, 1'b0, 1'b1, ROLE_IGNORED, METHOD_GET,  1'b0, 1'b0, ERR_NONE}
  };

  // dut ports, all known from time zero
  logic                clk;
  logic                rst          = 1'b1;
  logic                byte_valid   = 1'b0;
  logic                byte_stall;
  hrp_in_t             byte_item;
  logic                result_valid;
  logic                result_stall = 1'b0;
  hrp_out_t            result_item;
  logic                cfg_we       = 1'b0;
  logic [1:0]          cfg_index    = REG_MAX_URI;
  logic [LEN_BITS-1:0] cfg_data     = '0;

  // stimulus side
  byte_txn_t byte_backlog [$];
  byte_txn_t cur_txn = '0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        bytes_queued  = 0;
  logic      hold_arm  = 1'b0;
  logic      long_hold = 1'b0;

  // shadow parser state and limits
  phase_t              ph     = PH_METHOD;
  logic [POS_BITS-1:0] mpos   = '0;
  logic [LEN_BITS-1:0] flen   = '0;
  logic [1:0]          mcand  = 2'b11;
  method_t             mfound = METHOD_NONE;
  logic                pcr    = 1'b0;
  err_t                lerr   = ERR_NONE;
  logic [LEN_BITS-1:0] lim_uri = MAX_URI_RESET;
  logic [LEN_BITS-1:0] lim_key = MAX_KEY_RESET;
  logic [LEN_BITS-1:0] lim_val = MAX_VALUE_RESET;

  // expectations and bookkeeping
  hrp_out_t owed_results [$];
  hrp_out_t predicted;
  hrp_out_t owed;
  int       bytes_in     = 0;
  int       parsed_bytes = 0;
  int       results_seen = 0;
  int       headers_done = 0;
  int       mismatches   = 0;
  int       cycles       = 0;
  logic [6:0] roles_seen  = '0;
  logic [5:0] faults_seen = '0;

  assign byte_item = cur_txn.item;

  http_request_header_parser_top dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void restart_parse();
    ph     = PH_METHOD;
    mpos   = '0;
    flen   = '0;
    mcand  = 2'b11;
    mfound = METHOD_NONE;
    pcr    = 1'b0;
    lerr   = ERR_NONE;
  endfunction

  // length counter sticks at all ones
  function automatic void count_byte();
    if (flen != '1) flen = flen + 1'b1;
  endfunction

  function automatic void latch_fault(input err_t code);
    lerr = code;
    ph   = PH_ERROR;
    pcr  = 1'b0;
  endfunction

  // advance the shadow parser by one byte and return the result it owes
  function automatic hrp_out_t parse_byte(input hrp_in_t it);
    logic [7:0] b;
    role_t      role;
    logic       fend;
    logic       done;
    logic [1:0] cand;
    logic       line_closed;
    hrp_out_t   r;
    b = it.data_byte;
    role = ROLE_IGNORED;
    fend = 1'b0;
    done = 1'b0;
    line_closed = 1'b0;
    if (it.start_request) restart_parse();
    case (ph)
      PH_METHOD: begin
        // narrow the candidate set; a byte fitting neither is a bad method
        role = ROLE_METHOD;
        cand = mcand;
        if (mpos >= 4 || b != GET_STR[mpos]) cand[0] = 1'b0;
        if (mpos >= 5 || b != POST_STR[mpos]) cand[1] = 1'b0;
        if (cand == 2'b00) begin
          latch_fault(ERR_BAD_METHOD);
        end else if (cand[0] && mpos == 3) begin
          mfound = METHOD_GET;
          role = ROLE_DELIM;
          fend = 1'b1;
          ph = PH_URI;
          mpos = '0;
          flen = '0;
        end else if (cand[1] && mpos == 4) begin
          mfound = METHOD_POST;
          role = ROLE_DELIM;
          fend = 1'b1;
          ph = PH_URI;
          mpos = '0;
          flen = '0;
        end else begin
          mcand = cand;
          mpos = mpos + 1'b1;
        end
      end
      PH_URI: begin
        role = ROLE_URI;
        if (b == CH_SPACE) begin
          if (flen >= lim_uri) begin
            latch_fault(ERR_URI_LONG);
          end else begin
            role = ROLE_DELIM;
            fend = 1'b1;
            ph = PH_VERSION;
            mpos = '0;
            flen = '0;
          end
        end else begin
          count_byte();
          if (flen >= lim_uri) latch_fault(ERR_URI_LONG);
        end
      end
      PH_VERSION: begin
        role = ROLE_VERSION;
        if (mpos >= 10 || b != VER_STR[mpos]) begin
          latch_fault(ERR_BAD_VERSION);
        end else begin
          // the closing cr lf are delimiters
          role = (mpos < 8) ? ROLE_VERSION : ROLE_DELIM;
          if (mpos == 9) begin
            fend = 1'b1;
            ph = PH_KEY;
            mpos = '0;
            flen = '0;
            pcr = 1'b0;
          end else begin
            mpos = mpos + 1'b1;
          end
        end
      end
      PH_KEY: begin
        role = ROLE_KEY;
        if (pcr) begin
          pcr = 1'b0;
          if (b == CH_LF) begin
            role = ROLE_DELIM;
            done = 1'b1;
            ph = PH_DONE;
            line_closed = 1'b1;
          end else begin
            count_byte();
          end
        end
        if (!line_closed) begin
          if (flen == 0 && b == CH_CR) begin
            pcr = 1'b1;
            role = ROLE_DELIM;
          end else if (b == CH_COLON) begin
            if (flen >= lim_key) begin
              latch_fault(ERR_KEY_LONG);
            end else begin
              role = ROLE_DELIM;
              fend = 1'b1;
              ph = PH_VALUE;
              flen = '0;
            end
          end else begin
            count_byte();
            if (flen >= lim_key) latch_fault(ERR_KEY_LONG);
          end
        end
      end
      PH_VALUE: begin
        role = ROLE_VALUE;
        if (pcr) begin
          pcr = 1'b0;
          if (b == CH_LF) begin
            role = ROLE_DELIM;
            fend = 1'b1;
            ph = PH_KEY;
            flen = '0;
            line_closed = 1'b1;
          end else begin
            // the held cr turns out to be a value byte
            count_byte();
            if (flen > lim_val) begin
              latch_fault(ERR_VALUE_LONG);
              line_closed = 1'b1;
            end
          end
        end
        if (!line_closed) begin
          if (b == CH_CR) begin
            pcr = 1'b1;
            role = ROLE_DELIM;
          end else begin
            count_byte();
            if (flen > lim_val) latch_fault(ERR_VALUE_LONG);
          end
        end
      end
      default: role = ROLE_IGNORED;
    endcase
    r.byte_role    = role;
    r.echo_byte    = b;
    r.method_seen  = mfound;
    r.field_end    = fend;
    r.request_done = done;
    r.error_code   = lerr;
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  // sender: a new transaction only once the last one is taken; a stalled one holds
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || !byte_stall) begin
      if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        byte_valid <= 1'b1;
        cur_txn <= byte_backlog.pop_front();
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, or the long hold-off when it is on
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      result_stall <= long_hold || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // long receiver hold-off in the last phase, so the fifo fills and byte_stall rises
  initial begin
    wait (hold_arm);
    repeat (40) @(posedge clk);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (120) @(posedge clk);
    @(negedge clk);
    long_hold = 1'b0;
  end

  // ---------------------------------------------------------------- checking

  task automatic report_miss(input string what, input int unsigned want,
                             input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s at result %0d: expected %0d, got %0d",
               what, results_seen, want, got);
  endtask

  // every accepted byte owes exactly one result
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      predicted = parse_byte(cur_txn.item);
      bytes_in++;
      if (predicted.byte_role != ROLE_IGNORED) parsed_bytes++;
      owed_results.push_back(cur_txn.typed ? cur_txn.want : predicted);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      roles_seen[result_item.byte_role] = 1'b1;
      faults_seen[result_item.error_code] = 1'b1;
      if (result_item.request_done) headers_done++;
      if (owed_results.size() == 0) begin
        report_miss("result with nothing owed", 0, 32'(result_item));
      end else begin
        owed = owed_results.pop_front();
        if (result_item.byte_role !== owed.byte_role)
          report_miss("byte_role", 32'(owed.byte_role), 32'(result_item.byte_role));
        if (result_item.echo_byte !== owed.echo_byte)
          report_miss("echo_byte", 32'(owed.echo_byte), 32'(result_item.echo_byte));
        if (result_item.method_seen !== owed.method_seen)
          report_miss("method_seen", 32'(owed.method_seen),
                      32'(result_item.method_seen));
        if (result_item.field_end !== owed.field_end)
          report_miss("field_end", 32'(owed.field_end), 32'(result_item.field_end));
        if (result_item.request_done !== owed.request_done)
          report_miss("request_done", 32'(owed.request_done),
                      32'(result_item.request_done));
        if (result_item.error_code !== owed.error_code)
          report_miss("error_code", 32'(owed.error_code), 32'(result_item.error_code));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles,
               owed_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic put_byte(input logic [7:0] b, input logic s);
    byte_txn_t t;
    t = '0;
    t.item.data_byte = b;
    t.item.start_request = s;
    byte_backlog.push_back(t);
    bytes_queued++;
  endtask

  function automatic logic [7:0] any_byte_but(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] b;
    do b = 8'($urandom); while (b == x || b == y);
    return b;
  endfunction

  // mostly short fields; with a small limit, often right around it
  function automatic int pick_len(input logic [LEN_BITS-1:0] lim);
    int n;
    if (lim <= 40 && $urandom_range(0, 2) == 0) begin
      n = int'(lim) - 2 + int'($urandom_range(0, 3));
      if (n < 0) n = 0;
    end else begin
      n = $urandom_range(0, 5);
    end
    return n;
  endfunction

  // one request with random content; sometimes corrupted or cut short, sometimes noise
  task automatic gen_request();
    logic [7:0] req [$];
    int n;
    int cut;
    if ($urandom_range(0, 9) == 0) begin
      // stray bytes, now and then restarting the parser midway
      n = $urandom_range(1, 6);
      repeat (n) put_byte(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if ($urandom_range(0, 1) == 0) begin
      for (int i = 0; i < 4; i++) req.push_back(GET_STR[i]);
    end else begin
      for (int i = 0; i < 5; i++) req.push_back(POST_STR[i]);
    end
    if ($urandom_range(0, 9) == 0) req[$urandom_range(0, req.size() - 1)] = 8'($urandom);
    n = pick_len(lim_uri);
    repeat (n) req.push_back(any_byte_but(CH_SPACE, CH_SPACE));
    req.push_back(CH_SPACE);
    for (int i = 0; i < 10; i++) req.push_back(VER_STR[i]);
    if ($urandom_range(0, 11) == 0)
      req[req.size() - 1 - $urandom_range(0, 9)] = 8'($urandom);
    repeat ($urandom_range(0, 3)) begin
      // cr at key start that does not end the block
      if ($urandom_range(0, 7) == 0) begin
        req.push_back(CH_CR);
        req.push_back(any_byte_but(CH_LF, CH_CR));
      end
      n = pick_len(lim_key);
      repeat (n) req.push_back(any_byte_but(CH_COLON, CH_CR));
      req.push_back(CH_COLON);
      n = pick_len(lim_val);
      if (n > 0) begin
        req.push_back(CH_SPACE);
        repeat (n - 1) req.push_back(any_byte_but(CH_CR, CH_CR));
      end
      // lone cr inside a value
      if ($urandom_range(0, 7) == 0) begin
        req.push_back(CH_CR);
        req.push_back(any_byte_but(CH_LF, CH_CR));
      end
      req.push_back(CH_CR);
      req.push_back(CH_LF);
    end
    req.push_back(CH_CR);
    req.push_back(CH_LF);
    repeat ($urandom_range(0, 3)) req.push_back(8'($urandom));
    if ($urandom_range(0, 14) == 0) begin
      cut = $urandom_range(1, req.size());
      while (req.size() > cut) void'(req.pop_back());
    end
    foreach (req[i]) put_byte(req[i], i == 0);
  endtask

  // block is idle once nothing is queued, offered or owed
  task automatic wait_drained();
    do @(negedge clk); while (byte_backlog.size() != 0 || byte_valid ||
                              owed_results.size() != 0);
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    @(negedge clk);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  task automatic write_limit(input reg_index_t idx, input logic [LEN_BITS-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_MAX_URI:   lim_uri = val;
      REG_MAX_KEY:   lim_key = val;
      REG_MAX_VALUE: lim_val = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_limits(input logic [LEN_BITS-1:0] uri_lim,
                              input logic [LEN_BITS-1:0] key_lim,
                              input logic [LEN_BITS-1:0] val_lim);
    write_limit(REG_MAX_URI, uri_lim);
    write_limit(REG_MAX_KEY, key_lim);
    write_limit(REG_MAX_VALUE, val_lim);
  endtask

  // keep the sender fed until enough bytes were queued, then drain
  task automatic run_phase(input int target);
    int base;
    @(negedge clk);
    base = bytes_queued;
    while (bytes_queued - base < target) begin
      if (byte_backlog.size() < BACKLOG) gen_request();
      else @(negedge clk);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    byte_txn_t t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // sender rarely idles, receiver stalls about half the time
    set_idling(7, 51);

    // directed walk, reset limits
    for (int i = 0; i < DIR_ROWS; i++) begin
      t = '0;
      t.item.data_byte     = DIRECTED[i].data;
      t.item.start_request = DIRECTED[i].start;
      t.typed              = DIRECTED[i].typed;
      t.want.byte_role     = DIRECTED[i].role;
      t.want.echo_byte     = DIRECTED[i].data;
      t.want.method_seen   = DIRECTED[i].method;
      t.want.field_end     = DIRECTED[i].fend;
      t.want.request_done  = DIRECTED[i].done;
      t.want.error_code    = DIRECTED[i].err;
      byte_backlog.push_back(t);
    end
    wait_drained();

    // random requests under the reset limits
    run_phase(330);

    // tightest limits: any nonempty uri or key fails, values of one byte pass
    write_limits(LEN_BITS'(1), LEN_BITS'(1), LEN_BITS'(1));
    run_phase(150);

    // sender idles about half the time, receiver rarely stalls
    set_idling(51, 7);
    write_limits(LEN_BITS'($urandom_range(2, 16)), LEN_BITS'($urandom_range(2, 16)),
                 LEN_BITS'($urandom_range(1, 16)));
    run_phase(330);

    // widest limits
    write_limits(LEN_BITS'(4095), LEN_BITS'(4095), LEN_BITS'(4095));
    run_phase(150);

    // no idling at all, plus one long receiver hold-off
    set_idling(0, 0);
    write_limits(LEN_BITS'($urandom_range(2, 24)), LEN_BITS'($urandom_range(2, 24)),
                 LEN_BITS'($urandom_range(1, 24)));
    @(negedge clk);
    hold_arm = 1'b1;
    run_phase(330);

    // let anything stray come out before closing
    repeat (20) @(posedge clk);
    if (owed_results.size() != 0)
      report_miss("results never delivered", 0, owed_results.size());

    $display("%0d bytes fed, %0d parsed, %0d results compared, %0d header blocks closed",
             bytes_in, parsed_bytes, results_seen, headers_done);
    $display("roles seen %b, fault codes seen %b, limits at 1, 4095, reset and random",
             roles_seen, faults_seen);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/hrp_pkg.sv
sv/hrp_front.sv
sv/hrp_queue.sv
sv/hrp_back.sv
sv/http_request_header_parser_top.sv
sv/hrp_checker.sv
bench/http_request_header_parser_top_tb.sv
